### rtl/cspa_pkg.sv
`default_nettype none

package cspa_pkg;

  // Pool geometry
  localparam int SLOTS_PER_CHUNK = 64;
  localparam int CHUNK_COUNT     = 8;
  localparam int TOTAL_SLOTS     = CHUNK_COUNT * SLOTS_PER_CHUNK;

  // Fixed field widths of the request and result
  localparam int ADDR_W   = 9;
  localparam int STATUS_W = 2;

  // Derived widths
  localparam int SLOT_W  = $clog2(SLOTS_PER_CHUNK);
  localparam int CHUNK_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
  localparam int COUNT_W = $clog2(SLOTS_PER_CHUNK + 1);
  localparam int MEM_AW  = $clog2(TOTAL_SLOTS);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_OOM      = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = STATUS_W'(2);

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DECODE,
    CMD_SCAN,
    CMD_READ,
    CMD_TAKE,
    CMD_FREE,
    CMD_BAD_FREE,
    CMD_BUILD,
    CMD_ACTIVATE,
    CMD_OOM
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic alloc_hit;
    logic any_inactive;
    logic free_ok;
    logic build_last;
    logic out_free;
  } dp_status_t;

  // First link-memory address of a chunk
  function automatic logic [MEM_AW-1:0] chunk_base(input logic [CHUNK_W-1:0] c);
    chunk_base = MEM_AW'(c) * MEM_AW'(SLOTS_PER_CHUNK);
  endfunction

endpackage

`default_nettype wire

### rtl/cspa_req_if.sv
`default_nettype none

interface cspa_req_if;
  import cspa_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] freed_address;

  modport source (output valid, kind, freed_address, input ready);
  modport sink   (input valid, kind, freed_address, output ready);
endinterface

`default_nettype wire

### rtl/cspa_rsp_if.sv
`default_nettype none

interface cspa_rsp_if;
  import cspa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   slot_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, slot_address, status, input ready);
  modport sink   (input valid, slot_address, status, output ready);
endinterface

`default_nettype wire

### rtl/cspa_ctrl.sv
`default_nettype none

module cspa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_kind,
  output logic                      in_ready,
  output cspa_pkg::cmd_t            cmd,
  input  wire cspa_pkg::dp_status_t status
);
  import cspa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE,
    S_SCAN,
    S_READ,
    S_TAKE,
    S_BUILD,
    S_ACTIVATE,
    S_OOM
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd        = CMD_LOAD;
          state_next = (in_kind == KIND_FREE) ? S_DECODE : S_SCAN;
        end
      end
      S_DECODE: begin
        cmd        = CMD_DECODE;
        state_next = S_FREE;
      end
      S_FREE: begin
        if (status.out_free) begin
          cmd        = status.free_ok ? CMD_FREE : CMD_BAD_FREE;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        priority if (status.alloc_hit) begin
          state_next = S_READ;
        end else if (status.any_inactive) begin
          state_next = S_BUILD;
        end else begin
          state_next = S_OOM;
        end
      end
      S_READ: begin
        cmd        = CMD_READ;
        state_next = S_TAKE;
      end
      S_TAKE: begin
        if (status.out_free) begin
          cmd        = CMD_TAKE;
          state_next = S_IDLE;
        end
      end
      S_BUILD: begin
        cmd = CMD_BUILD;
        if (status.build_last) begin
          state_next = S_ACTIVATE;
        end
      end
      S_ACTIVATE: begin
        if (status.out_free) begin
          cmd        = CMD_ACTIVATE;
          state_next = S_IDLE;
        end
      end
      S_OOM: begin
        if (status.out_free) begin
          cmd        = CMD_OOM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  // A finished chain build always hands over to chunk activation
  a_build_to_activate: assert property (@(posedge clk) disable iff (rst)
    (state == S_BUILD && status.build_last) |=> (state == S_ACTIVATE))
    else $error("chain build did not end in activation");

  // Never commit a result while the output register is still occupied
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_TAKE || cmd == CMD_FREE || cmd == CMD_BAD_FREE ||
     cmd == CMD_ACTIVATE || cmd == CMD_OOM) |-> status.out_free)
    else $error("result committed into a full output register");

  // A scan with no hit and no inactive chunk must report out of memory
  a_scan_oom: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !status.alloc_hit && !status.any_inactive) |=> (state == S_OOM))
    else $error("exhausted pool not reported");

endmodule

`default_nettype wire

### rtl/cspa_dp.sv
`default_nettype none

module cspa_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [cspa_pkg::ADDR_W-1:0]   freed_address,
  input  wire cspa_pkg::cmd_t                cmd,
  output cspa_pkg::dp_status_t               status,
  cspa_rsp_if.source                         rsp
);
  import cspa_pkg::*;

  // Per-chunk bookkeeping
  logic                chunk_active [CHUNK_COUNT];
  logic [COUNT_W-1:0]  free_count   [CHUNK_COUNT];
  logic [SLOT_W-1:0]   free_head    [CHUNK_COUNT];

  // Link memory, undefined until written
  logic [SLOT_W-1:0]   next_link [TOTAL_SLOTS];
  logic [SLOT_W-1:0]   link_q;

  // Working registers
  logic [ADDR_W-1:0]   addr_q;
  logic [CHUNK_W-1:0]  chunk_sel;
  logic                in_range_q;
  logic [SLOT_W-1:0]   build_idx;

  // Output register
  logic                out_valid;
  logic [ADDR_W-1:0]   out_addr;
  logic [STATUS_W-1:0] out_status;

  logic [CHUNK_W-1:0]  hit_idx;
  logic [CHUNK_W-1:0]  inact_idx;
  logic                alloc_hit;
  logic                any_inactive;
  logic [CHUNK_W-1:0]  dec_idx;
  logic                dec_in_range;
  logic [MEM_AW-1:0]   base;
  logic [SLOT_W-1:0]   free_slot;
  logic [COUNT_W-1:0]  cnt_inc;
  logic                build_last;
  logic                out_free;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [SLOT_W-1:0]   mem_wdata;

  // Lowest active chunk with a free slot, lowest inactive chunk
  always_comb begin
    hit_idx      = '0;
    inact_idx    = '0;
    alloc_hit    = 1'b0;
    any_inactive = 1'b0;
    for (int c = CHUNK_COUNT - 1; c >= 0; c--) begin
      if (chunk_active[c] && free_count[c] != '0) begin
        hit_idx   = CHUNK_W'(c);
        alloc_hit = 1'b1;
      end
      if (!chunk_active[c]) begin
        inact_idx    = CHUNK_W'(c);
        any_inactive = 1'b1;
      end
    end
  end

  // Chunk number of the address to free
  always_comb begin
    dec_idx      = '0;
    dec_in_range = (int'(addr_q) < TOTAL_SLOTS);
    for (int c = 0; c < CHUNK_COUNT; c++) begin
      if (int'(addr_q) >= c * SLOTS_PER_CHUNK) begin
        dec_idx = CHUNK_W'(c);
      end
    end
  end

  assign base       = chunk_base(chunk_sel);
  assign free_slot  = SLOT_W'(int'(addr_q) - int'(base));
  assign cnt_inc    = free_count[chunk_sel] + COUNT_W'(1);
  assign build_last = (build_idx == SLOT_W'(SLOTS_PER_CHUNK - 1));
  assign out_free   = !out_valid || rsp.ready;

  assign mem_we    = (cmd == CMD_FREE) || (cmd == CMD_BUILD);
  assign mem_waddr = (cmd == CMD_FREE) ? base + MEM_AW'(free_slot) : base + MEM_AW'(build_idx);
  assign mem_wdata = (cmd == CMD_FREE) ? free_head[chunk_sel] :
                     (build_last ? '0 : build_idx + SLOT_W'(1));

  always_comb begin
    status.alloc_hit    = alloc_hit;
    status.any_inactive = any_inactive;
    status.free_ok      = in_range_q && chunk_active[chunk_sel];
    status.build_last   = build_last;
    status.out_free     = out_free;
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      next_link[mem_waddr] <= mem_wdata;
    end
    if (cmd == CMD_READ) begin
      link_q <= next_link[base + MEM_AW'(free_head[chunk_sel])];
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        addr_q <= freed_address;
      end
      CMD_DECODE: begin
        chunk_sel  <= dec_idx;
        in_range_q <= dec_in_range;
      end
      CMD_SCAN: begin
        chunk_sel <= alloc_hit ? hit_idx : inact_idx;
        build_idx <= '0;
      end
      CMD_BUILD: begin
        build_idx <= build_idx + SLOT_W'(1);
      end
      CMD_TAKE: begin
        out_addr   <= ADDR_W'(base + MEM_AW'(free_head[chunk_sel]));
        out_status <= STATUS_OK;
      end
      CMD_ACTIVATE: begin
        out_addr   <= ADDR_W'(base);
        out_status <= STATUS_OK;
      end
      CMD_FREE: begin
        out_addr   <= '0;
        out_status <= STATUS_OK;
      end
      CMD_BAD_FREE: begin
        out_addr   <= '0;
        out_status <= STATUS_BAD_FREE;
      end
      CMD_OOM: begin
        out_addr   <= '0;
        out_status <= STATUS_OOM;
      end
      default: begin
      end
    endcase
  end

  // Chunk state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int c = 0; c < CHUNK_COUNT; c++) begin
        chunk_active[c] <= 1'b0;
        free_count[c]   <= '0;
        free_head[c]    <= '0;
      end
    end else begin
      unique case (cmd)
        CMD_TAKE: begin
          free_head[chunk_sel]  <= link_q;
          free_count[chunk_sel] <= free_count[chunk_sel] - COUNT_W'(1);
        end
        CMD_ACTIVATE: begin
          // slot 0 is handed out at once, so the head moves to slot 1
          chunk_active[chunk_sel] <= 1'b1;
          free_head[chunk_sel]    <= SLOT_W'(1);
          free_count[chunk_sel]   <= COUNT_W'(SLOTS_PER_CHUNK - 1);
        end
        CMD_FREE: begin
          if (int'(cnt_inc) >= SLOTS_PER_CHUNK) begin
            chunk_active[chunk_sel] <= 1'b0;
            free_count[chunk_sel]   <= '0;
            free_head[chunk_sel]    <= '0;
          end else begin
            free_head[chunk_sel]  <= free_slot;
            free_count[chunk_sel] <= cnt_inc;
          end
        end
        default: begin
        end
      endcase

      if (cmd == CMD_TAKE || cmd == CMD_ACTIVATE || cmd == CMD_FREE ||
          cmd == CMD_BAD_FREE || cmd == CMD_OOM) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.slot_address = out_addr;
  assign rsp.status       = out_status;

  // An inactive chunk holds no free count
  a_inactive_empty: assert property (@(posedge clk) disable iff (rst)
    !chunk_active[chunk_sel] |-> (free_count[chunk_sel] == '0))
    else $error("inactive chunk with nonzero free count");

  // An active chunk never counts more free slots than it has
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    chunk_active[chunk_sel] |-> (int'(free_count[chunk_sel]) < SLOTS_PER_CHUNK))
    else $error("free count exceeds chunk size");

  // A taken slot leaves a valid ok result behind
  a_take_result: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_TAKE) |=> (out_valid && out_status == STATUS_OK))
    else $error("allocate commit produced no ok result");

endmodule

`default_nettype wire

### rtl/chunked_slot_pool_allocator_unit.sv
`default_nettype none

// Chunked slot pool allocator. Each request on req either allocates a slot
// (kind 0) or frees freed_address (kind 1); each gives exactly one result on
// rsp with slot_address and status (0 ok, 1 out of memory, 2 free outside the
// active chunks). The pool has CHUNK_COUNT chunks of SLOTS_PER_CHUNK slots,
// each with its own free list threaded through a single-port-write link
// memory. Once accepted, an allocate served from an active chunk goes through
// scan, link memory read and commit; a free goes through decode and commit;
// an allocate that must activate a new chunk goes through scan, a chain build
// that writes the new chunk's chain into the link memory one entry per cycle,
// and activation; out of memory goes through scan and commit. The block
// handles one request at a time and is ready again the cycle its result is
// registered; the result register lets the next request in while the
// previous result waits on rsp. No clearing pass is needed after reset.
module chunked_slot_pool_allocator_unit (
  input wire logic clk,
  input wire logic rst,
  cspa_req_if.sink   req,
  cspa_rsp_if.source rsp
);
  import cspa_pkg::*;

  cmd_t       cmd;
  dp_status_t status;
  logic       in_ready;

  // Sequence each request: decode or scan, link memory read or chain build where needed, commit
  cspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Hold chunk bookkeeping, the link memory and the result register
  cspa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .freed_address (req.freed_address),
    .cmd           (cmd),
    .status        (status),
    .rsp           (rsp)
  );

  assign req.ready = in_ready;

endmodule

`default_nettype wire
